[hdl/bsc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared types and constants of the binary stripe code decoder.
// ----------------------------------------------------------------------------
package bsc_pkg;

  localparam int DEF_IMAGE_WIDTH  = 640;
  localparam int DEF_IMAGE_HEIGHT = 480;
  localparam int DEF_CODE_BITS    = 8;

  localparam int TH_W       = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int PX_W       = 10;
  localparam int PY_W       = 9;
  localparam int CHAN_W     = 8;
  localparam int COLUMN_W   = 8;
  localparam int CAM_W      = 10;
  localparam int CMP_W      = 16;

  localparam logic signed [TH_W-1:0] DARK_RESET  = -11'sd50;
  localparam logic signed [TH_W-1:0] LIGHT_RESET = 11'sd50;

  localparam logic [CFG_IDX_W-1:0] REG_DARK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT = 2'd1;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_ACCUM = 2'd1,
    ACT_QUERY = 2'd2,
    ACT_NOP   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    PC_ZERO   = 2'd0,
    PC_ONE    = 2'd1,
    PC_UNSURE = 2'd2,
    PC_NONE   = 2'd3
  } pixel_class_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_ACC_READ,
    ST_ACC_WRITE,
    ST_SCAN,
    ST_EMIT
  } state_t;

endpackage

[hdl/bsc_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_req_if
// Request channel: one action with its pixel pair or query column.
// ----------------------------------------------------------------------------
interface bsc_req_if import bsc_pkg::*; ();
  logic                valid;
  logic                ready;
  action_t             action;
  logic [PX_W-1:0]     pixel_x;
  logic [PY_W-1:0]     pixel_y;
  logic [CHAN_W-1:0]   pos_blue;
  logic [CHAN_W-1:0]   pos_green;
  logic [CHAN_W-1:0]   pos_red;
  logic [CHAN_W-1:0]   neg_blue;
  logic [CHAN_W-1:0]   neg_green;
  logic [CHAN_W-1:0]   neg_red;
  logic [COLUMN_W-1:0] projector_column;

  modport source (
    output valid, action, pixel_x, pixel_y, pos_blue, pos_green, pos_red,
           neg_blue, neg_green, neg_red, projector_column,
    input  ready
  );
  modport sink (
    input  valid, action, pixel_x, pixel_y, pos_blue, pos_green, pos_red,
           neg_blue, neg_green, neg_red, projector_column,
    output ready
  );
endinterface

[hdl/bsc_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_rsp_if
// Response channel: one result for every request.
// ----------------------------------------------------------------------------
interface bsc_rsp_if import bsc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             found;
  logic [CAM_W-1:0] camera_column;
  pixel_class_t     pixel_class;

  modport source (output valid, found, camera_column, pixel_class, input ready);
  modport sink (input valid, found, camera_column, pixel_class, output ready);
endinterface

[hdl/bsc_cfg_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface bsc_cfg_if import bsc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [TH_W-1:0]      value;

  modport source (output valid, index, value, input ready);
  modport sink (input valid, index, value, output ready);
endinterface

[hdl/bsc_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module bsc_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[hdl/bsc_classify.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_classify
// Sums both captures, takes their difference and classifies it, registered.
// ----------------------------------------------------------------------------
module bsc_classify import bsc_pkg::*; (
  input  logic                   clk,
  input  logic [CHAN_W-1:0]      pos_blue,
  input  logic [CHAN_W-1:0]      pos_green,
  input  logic [CHAN_W-1:0]      pos_red,
  input  logic [CHAN_W-1:0]      neg_blue,
  input  logic [CHAN_W-1:0]      neg_green,
  input  logic [CHAN_W-1:0]      neg_red,
  input  logic signed [TH_W-1:0] dark_threshold,
  input  logic signed [TH_W-1:0] light_threshold,
  output pixel_class_t           pixel_class
);

  logic [TH_W-2:0]        pos_sum;
  logic [TH_W-2:0]        neg_sum;
  logic signed [TH_W-1:0] diff;
  pixel_class_t           cls;

  always_comb begin
    pos_sum = (TH_W-1)'(pos_blue) + (TH_W-1)'(pos_green) + (TH_W-1)'(pos_red);
    neg_sum = (TH_W-1)'(neg_blue) + (TH_W-1)'(neg_green) + (TH_W-1)'(neg_red);
    // Both sums stay below 766, so the difference fits the threshold width.
    diff = $signed({1'b0, pos_sum}) - $signed({1'b0, neg_sum});
    if (diff < dark_threshold) begin
      cls = PC_ONE;
    end else if (diff > light_threshold) begin
      cls = PC_ZERO;
    end else begin
      cls = PC_UNSURE;
    end
  end

  always_ff @(posedge clk) begin
    pixel_class <= cls;
  end

endmodule

[hdl/binary_stripe_code_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_stripe_code_decoder
// Per-pixel stripe code store with accumulate, clear and row query actions.
// ----------------------------------------------------------------------------
// One request is worked on at a time; every request gives one response, held
// in an output register so the next request can be taken while it waits. All
// timing is set by the single-port code RAM, one access per cycle: an
// accumulate reads, modifies and writes back its entry, a query reads its row
// one pixel per cycle and stops at the first match, a no-operation or an
// out-of-range pixel goes straight to its response, and a clear writes every
// entry. After reset the same sweep over every entry runs before the first
// request is taken; configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module binary_stripe_code_decoder import bsc_pkg::*; #(
  parameter int IMAGE_WIDTH  = DEF_IMAGE_WIDTH,
  parameter int IMAGE_HEIGHT = DEF_IMAGE_HEIGHT,
  parameter int CODE_BITS    = DEF_CODE_BITS
) (
  input  logic      clk,
  input  logic      rst,
  bsc_cfg_if.sink   cfg,
  bsc_req_if.sink   req,
  bsc_rsp_if.source rsp
);

  localparam int PIXELS = IMAGE_WIDTH * IMAGE_HEIGHT;
  localparam int ADDR_W = $clog2(PIXELS);
  localparam int XW     = $clog2(IMAGE_WIDTH);
  localparam int EW     = CODE_BITS + 1;
  localparam logic [XW-1:0]     LAST_X    = XW'(IMAGE_WIDTH - 1);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(PIXELS - 1);

  state_t state;
  state_t state_next;

  logic signed [TH_W-1:0] dark_threshold;
  logic signed [TH_W-1:0] light_threshold;

  // Request held for the whole transaction.
  action_t             act;
  logic [PX_W-1:0]     px;
  logic [PY_W-1:0]     py;
  logic [CHAN_W-1:0]   pos_b, pos_g, pos_r, neg_b, neg_g, neg_r;
  logic [COLUMN_W-1:0] column;

  pixel_class_t  cls;
  logic          px_ok;
  logic          py_ok;

  logic [ADDR_W-1:0] row_base;
  logic [ADDR_W-1:0] acc_addr;
  logic [ADDR_W-1:0] clr_addr;
  logic              clr_emit;

  logic [XW-1:0] scan_x;
  logic          scan_end;
  logic [XW-1:0] cmp_x;
  logic          cmp_valid;
  logic          hit;

  logic [XW-1:0] prev_match;
  logic          prev_valid;
  logic          res_found;
  logic [XW-1:0] res_x;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [EW-1:0]     ram_wdata;
  logic [EW-1:0]     ram_rdata;

  logic              rsp_valid;
  logic              rsp_found;
  logic [CAM_W-1:0]  rsp_column;
  pixel_class_t      rsp_class;

  // Each entry is an invalid mark above the code; all zero is a valid code 0.
  bsc_ram #(
    .WIDTH (EW),
    .DEPTH (PIXELS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  bsc_classify u_classify (
    .clk             (clk),
    .pos_blue        (pos_b),
    .pos_green       (pos_g),
    .pos_red         (pos_r),
    .neg_blue        (neg_b),
    .neg_green       (neg_g),
    .neg_red         (neg_r),
    .dark_threshold  (dark_threshold),
    .light_threshold (light_threshold),
    .pixel_class     (cls)
  );

  assign cfg.ready = 1'b1;
  assign req.ready = (state == ST_IDLE);

  assign rsp.valid         = rsp_valid;
  assign rsp.found         = rsp_found;
  assign rsp.camera_column = rsp_column;
  assign rsp.pixel_class   = rsp_class;

  assign px_ok = (32'(px) < IMAGE_WIDTH);
  assign py_ok = (32'(py) < IMAGE_HEIGHT);
  assign hit   = !ram_rdata[CODE_BITS]
              && (CMP_W'(ram_rdata[CODE_BITS-1:0]) == CMP_W'(column));

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == LAST_ADDR) begin
          state_next = clr_emit ? ST_EMIT : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req.valid) begin
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (act)
          ACT_CLEAR: state_next = ST_CLEAR;
          ACT_ACCUM: state_next = (px_ok && py_ok) ? ST_ACC_READ : ST_EMIT;
          ACT_QUERY: state_next = py_ok ? ST_SCAN : ST_EMIT;
          default:   state_next = ST_EMIT;
        endcase
      end
      ST_ACC_READ:  state_next = ST_ACC_WRITE;
      ST_ACC_WRITE: state_next = ST_EMIT;
      ST_SCAN: begin
        if (cmp_valid && (hit || cmp_x == LAST_X)) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!rsp_valid || rsp.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // RAM port control.
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = row_base + ADDR_W'(scan_x);
    ram_wdata = '0;
    case (state)
      ST_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_addr;
      end
      ST_ACC_READ: begin
        ram_addr = row_base + ADDR_W'(px);
      end
      ST_ACC_WRITE: begin
        ram_we   = 1'b1;
        ram_addr = acc_addr;
        if (cls == PC_UNSURE) begin
          ram_wdata = {1'b1, ram_rdata[CODE_BITS-1:0]};
        end else begin
          // The shift drops the top code bit, so codes wrap.
          ram_wdata = {ram_rdata[CODE_BITS],
                       CODE_BITS'({ram_rdata[CODE_BITS-1:0], cls[0]})};
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_CLEAR;
      dark_threshold  <= DARK_RESET;
      light_threshold <= LIGHT_RESET;
      clr_addr        <= '0;
      clr_emit        <= 1'b0;
      prev_valid      <= 1'b0;
      cmp_valid       <= 1'b0;
      rsp_valid       <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg.valid) begin
        if (cfg.index == REG_DARK) begin
          dark_threshold <= $signed(cfg.value);
        end else if (cfg.index == REG_LIGHT) begin
          light_threshold <= $signed(cfg.value);
        end
      end

      // A new result may load in the same cycle the waiting one is taken.
      if (state == ST_EMIT && (!rsp_valid || rsp.ready)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end

      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
        end
        ST_DECODE: begin
          cmp_valid <= 1'b0;
          if (act == ACT_CLEAR) begin
            clr_addr <= '0;
            clr_emit <= 1'b1;
          end
          if (act == ACT_QUERY && column == '0) begin
            prev_valid <= 1'b0;
          end
        end
        ST_SCAN: begin
          if (!scan_end) begin
            cmp_valid <= 1'b1;
          end else begin
            cmp_valid <= 1'b0;
          end
          if (cmp_valid && hit && !(prev_valid && prev_match == cmp_x)) begin
            prev_match <= cmp_x;
            prev_valid <= 1'b1;
          end
        end
        default: begin
          cmp_valid <= 1'b0;
        end
      endcase
    end
  end

  // Payload and datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (req.valid) begin
          act    <= req.action;
          px     <= req.pixel_x;
          py     <= req.pixel_y;
          pos_b  <= req.pos_blue;
          pos_g  <= req.pos_green;
          pos_r  <= req.pos_red;
          neg_b  <= req.neg_blue;
          neg_g  <= req.neg_green;
          neg_r  <= req.neg_red;
          column <= req.projector_column;
        end
      end
      ST_DECODE: begin
        row_base  <= ADDR_W'(py) * ADDR_W'(IMAGE_WIDTH);
        scan_x    <= '0;
        scan_end  <= 1'b0;
        res_found <= 1'b0;
        res_x     <= '0;
      end
      ST_ACC_READ: begin
        acc_addr <= row_base + ADDR_W'(px);
      end
      ST_SCAN: begin
        if (!scan_end) begin
          cmp_x <= scan_x;
          if (scan_x == LAST_X) begin
            scan_end <= 1'b1;
          end else begin
            scan_x <= scan_x + 1'b1;
          end
        end
        if (cmp_valid && hit && !(prev_valid && prev_match == cmp_x)) begin
          res_found <= 1'b1;
          res_x     <= cmp_x;
        end
      end
      ST_EMIT: begin
        if (!rsp_valid || rsp.ready) begin
          rsp_found  <= res_found && (act == ACT_QUERY);
          rsp_column <= (res_found && act == ACT_QUERY) ? CAM_W'(res_x) : '0;
          rsp_class  <= (act == ACT_ACCUM) ? cls : PC_NONE;
        end
      end
      default: begin
        scan_end <= scan_end;
      end
    endcase
  end

  // A reported match is always the one now remembered.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && act == ACT_QUERY && res_found)
      |-> (prev_valid && prev_match == res_x))
    else $error("reported match differs from remembered match");

  // The row scan never compares past the last column.
  assert property (@(posedge clk) disable iff (rst)
    cmp_valid |-> (32'(cmp_x) < IMAGE_WIDTH))
    else $error("row scan ran past the image width");

  // An accumulate write back lands inside the image.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_ACC_WRITE) |-> (32'(acc_addr) < PIXELS))
    else $error("accumulate address outside the store");

  // A finished result waits while the response register still holds one not yet taken.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && rsp_valid && !rsp.ready) |=> (state == ST_EMIT))
    else $error("response overwritten before it was taken");

endmodule
